>>> rtl/core/voting_symbol_deframer_macros.svh
// Assertion macros used by the deframer top level.
`ifndef VOTING_SYMBOL_DEFRAMER_MACROS_SVH
`define VOTING_SYMBOL_DEFRAMER_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define VSD_ASSERT_NOW(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define VSD_ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

>>> rtl/core/vsd_pkg.sv
// Shared constants and types for the voting symbol deframer.
package vsd_pkg;

	localparam int MTU_DEF       = 256;
	localparam int SLOTS_DEF     = 64;
	localparam int VOTE_BITS_DEF = 8;

	// symbol code map
	localparam logic [9:0] CODE_DATA_END = 10'd256;
	localparam logic [9:0] CODE_PRE      = 10'd270;
	localparam logic [9:0] CODE_SEP      = 10'd275;
	localparam logic [9:0] CODE_POST     = 10'd280;
	localparam logic [9:0] CODE_LAST     = 10'd285;

	// item kinds
	localparam logic [1:0] KIND_SYMBOL = 2'd0;
	localparam logic [1:0] KIND_READ   = 2'd1;
	localparam logic [1:0] KIND_POP    = 2'd2;

	// receive mode as reported
	localparam logic [1:0] MODE_WAIT    = 2'd0;
	localparam logic [1:0] MODE_COLLECT = 2'd1;
	localparam logic [1:0] MODE_DISCARD = 2'd2;

	typedef enum logic [2:0] {
		RX_WAIT    = 3'b001,
		RX_COLLECT = 3'b010,
		RX_DISCARD = 3'b100
	} rx_state_t;

	// vote tally control, applied at the edge the item leaves stage 1
	typedef struct packed {
		logic tally;
		logic clear;
	} vote_ctl_t;

endpackage

>>> rtl/core/vsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/core/vsd_vote.sv
// Byte vote tally: per-value counters in RAM, valid bits, running best value.
module vsd_vote #(
	parameter int VOTE_BITS = vsd_pkg::VOTE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [7:0]          rd_sym,
	input  logic [7:0]          cur_sym,
	input  vsd_pkg::vote_ctl_t  ctl,
	output logic [7:0]          best_value
);

	logic [VOTE_BITS-1:0] rdata;
	logic [VOTE_BITS-1:0] fwd_data_q;
	logic                 fwd_hit_q;
	logic [255:0]         valid_q;
	logic [VOTE_BITS-1:0] best_count_q;
	logic [7:0]           best_value_q;
	logic [VOTE_BITS-1:0] cnt_old;
	logic [VOTE_BITS-1:0] cnt_new;
	logic                 better;

	vsd_ram #(.WIDTH(VOTE_BITS), .DEPTH(256)) u_cnt_ram (
		.clk   (clk),
		.we    (ctl.tally),
		.waddr (cur_sym),
		.wdata (cnt_new),
		.re    (rd_en),
		.raddr (rd_sym),
		.rdata (rdata)
	);

	// a count written at the same edge as the read is taken from the bypass
	always_comb begin
		cnt_old = '0;
		if (valid_q[cur_sym]) begin
			cnt_old = fwd_hit_q ? fwd_data_q : rdata;
		end
		cnt_new = (cnt_old == {VOTE_BITS{1'b1}}) ? cnt_old : cnt_old + 1'b1;
		better  = (cnt_new > best_count_q) ||
			((cnt_new == best_count_q) && (cur_sym < best_value_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else if (rd_en) begin
			fwd_hit_q <= ctl.tally && (rd_sym == cur_sym);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_data_q <= cnt_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			best_count_q <= '0;
			best_value_q <= '0;
		end else if (ctl.clear) begin
			valid_q      <= '0;
			best_count_q <= '0;
			best_value_q <= '0;
		end else if (ctl.tally) begin
			valid_q[cur_sym] <= 1'b1;
			if (better) begin
				best_count_q <= cnt_new;
				best_value_q <= cur_sym;
			end
		end
	end

	assign best_value = best_value_q;

endmodule

>>> rtl/core/voting_symbol_deframer.sv
// Voting symbol deframer top level: framing control, slot ring and result stage.
//
//  channel | signals                                       | role
//  in      | in_valid, in_ready, kind, symbol_value,       | symbol, read or pop beat
//          | byte_index                                    |
//  out     | out_valid, out_ready, packet_ready,           | one status beat per in beat
//          | packet_length, data_byte, pop_done,           |
//          | receive_mode                                  |
//
// One beat accepted per cycle while in_ready is high.
// Stage 1 holds the beat and the vote count read at accept; the vote, packet and
// length RAMs are written as it moves to the output register.
// in_ready falls only while both stages are full and out_ready is low.
// Reset clears control state and the vote valid bits; no clearing pass is needed.
`include "voting_symbol_deframer_macros.svh"

module voting_symbol_deframer #(
	parameter int MTU       = vsd_pkg::MTU_DEF,
	parameter int SLOTS     = vsd_pkg::SLOTS_DEF,
	parameter int VOTE_BITS = vsd_pkg::VOTE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] kind,
	input  logic [9:0] symbol_value,
	input  logic [7:0] byte_index,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       packet_ready,
	output logic [8:0] packet_length,
	output logic [7:0] data_byte,
	output logic       pop_done,
	output logic [1:0] receive_mode
);

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LEN_W  = $clog2(MTU + 1);
	localparam int LW     = (LEN_W > 9) ? LEN_W : 9;
	localparam int ADDR_W = $clog2(SLOTS * MTU);

	// stage 1
	logic                s1_valid_q;
	logic [1:0]          kind_s1;
	logic [9:0]          sym_s1;
	logic [7:0]          idx_s1;
	logic                s1_adv;
	logic                in_acc;

	// state
	vsd_pkg::rx_state_t  mode_q, mode_d;
	logic                byte_voted_q, byte_voted_d;
	logic [LEN_W-1:0]    wr_len_q, wr_len_d;
	logic [SLOT_W-1:0]   ws_q, ws_d, rs_q, rs_d;
	logic [SLOTS-1:0]    slot_ready_q, slot_ready_d;

	// stage 1 decode
	logic                is_data, is_pre, is_sep, is_post;
	vsd_pkg::vote_ctl_t  vctl, vctl_gated;
	logic                byte_we, len_we, pop_now, rs_ready, len_fwd;
	logic [1:0]          mode_code;
	logic [7:0]          best_value;
	logic [ADDR_W-1:0]   byte_waddr, byte_raddr;

	// stage 2 / output register
	logic                s2_valid_q;
	logic                ready_s2, pop_s2, read_s2, len_fwd_s2;
	logic [1:0]          mode_s2;
	logic [7:0]          idx_s2;
	logic [LEN_W-1:0]    len_val_s2;
	logic [7:0]          byte_rdata;
	logic [LEN_W-1:0]    len_rdata;
	logic [LEN_W-1:0]    len_sel;
	logic [LW-1:0]       len_ext;

	assign s1_adv   = s1_valid_q && (!s2_valid_q || out_ready);
	assign in_ready = !s1_valid_q || s1_adv;
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s1 <= kind;
			sym_s1  <= symbol_value;
			idx_s1  <= byte_index;
		end
	end

	always_comb begin
		is_data = sym_s1 < vsd_pkg::CODE_DATA_END;
		is_pre  = sym_s1 inside {[vsd_pkg::CODE_PRE : vsd_pkg::CODE_SEP - 10'd1]};
		is_sep  = sym_s1 inside {[vsd_pkg::CODE_SEP : vsd_pkg::CODE_POST - 10'd1]};
		is_post = sym_s1 inside {[vsd_pkg::CODE_POST : vsd_pkg::CODE_LAST]};
	end

	always_comb begin
		mode_d       = mode_q;
		byte_voted_d = byte_voted_q;
		wr_len_d     = wr_len_q;
		ws_d         = ws_q;
		rs_d         = rs_q;
		slot_ready_d = slot_ready_q;
		vctl         = '0;
		byte_we      = 1'b0;
		len_we       = 1'b0;
		pop_now      = 1'b0;

		if (s1_valid_q && (kind_s1 == vsd_pkg::KIND_SYMBOL)) begin
			if (is_data) begin
				if (mode_q == vsd_pkg::RX_COLLECT) begin
					vctl.tally   = 1'b1;
					byte_voted_d = 1'b1;
				end
			end else if (is_pre) begin
				if (mode_q == vsd_pkg::RX_WAIT) begin
					if (slot_ready_q[ws_q]) begin
						mode_d = vsd_pkg::RX_DISCARD;
					end else begin
						mode_d   = vsd_pkg::RX_COLLECT;
						wr_len_d = '0;
					end
				end
			end else if (is_sep) begin
				if ((mode_q == vsd_pkg::RX_COLLECT) && byte_voted_q) begin
					byte_voted_d = 1'b0;
					vctl.clear   = 1'b1;
					if (wr_len_q >= LEN_W'(MTU)) begin
						mode_d = vsd_pkg::RX_DISCARD;
					end else begin
						byte_we  = 1'b1;
						wr_len_d = LEN_W'(wr_len_q + 1'b1);
					end
				end
			end else if (is_post) begin
				if (mode_q == vsd_pkg::RX_COLLECT) begin
					if (wr_len_q != '0) begin
						slot_ready_d[ws_q] = 1'b1;
						len_we             = 1'b1;
						ws_d = (ws_q == SLOT_W'(SLOTS - 1)) ? '0 : SLOT_W'(ws_q + 1'b1);
					end
					vctl.clear   = 1'b1;
					byte_voted_d = 1'b0;
				end
				mode_d = vsd_pkg::RX_WAIT;
			end
		end

		// status is sampled after symbol handling, before the pop
		rs_ready = slot_ready_d[rs_q];
		len_fwd  = len_we && (ws_q == rs_q);

		if (s1_valid_q && (kind_s1 == vsd_pkg::KIND_POP) && rs_ready) begin
			slot_ready_d[rs_q] = 1'b0;
			rs_d    = (rs_q == SLOT_W'(SLOTS - 1)) ? '0 : SLOT_W'(rs_q + 1'b1);
			pop_now = 1'b1;
		end
	end

	always_comb begin
		case (mode_d)
			vsd_pkg::RX_COLLECT: mode_code = vsd_pkg::MODE_COLLECT;
			vsd_pkg::RX_DISCARD: mode_code = vsd_pkg::MODE_DISCARD;
			default:             mode_code = vsd_pkg::MODE_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= vsd_pkg::RX_WAIT;
			byte_voted_q <= 1'b0;
			wr_len_q     <= '0;
			ws_q         <= '0;
			rs_q         <= '0;
			slot_ready_q <= '0;
		end else if (s1_adv) begin
			mode_q       <= mode_d;
			byte_voted_q <= byte_voted_d;
			wr_len_q     <= wr_len_d;
			ws_q         <= ws_d;
			rs_q         <= rs_d;
			slot_ready_q <= slot_ready_d;
		end
	end

	assign vctl_gated.tally = vctl.tally && s1_adv;
	assign vctl_gated.clear = vctl.clear && s1_adv;

	vsd_vote #(.VOTE_BITS(VOTE_BITS)) u_vote (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (in_acc),
		.rd_sym     (symbol_value[7:0]),
		.cur_sym    (sym_s1[7:0]),
		.ctl        (vctl_gated),
		.best_value (best_value)
	);

	assign byte_waddr = ADDR_W'(32'(ws_q) * MTU + 32'(wr_len_q));
	assign byte_raddr = ADDR_W'(32'(rs_q) * MTU + 32'(idx_s1));

	vsd_ram #(.WIDTH(8), .DEPTH(SLOTS * MTU)) u_byte_ram (
		.clk   (clk),
		.we    (byte_we && s1_adv),
		.waddr (byte_waddr),
		.wdata (best_value),
		.re    (s1_adv),
		.raddr (byte_raddr),
		.rdata (byte_rdata)
	);

	vsd_ram #(.WIDTH(LEN_W), .DEPTH(SLOTS)) u_len_ram (
		.clk   (clk),
		.we    (len_we && s1_adv),
		.waddr (ws_q),
		.wdata (wr_len_q),
		.re    (s1_adv),
		.raddr (rs_q),
		.rdata (len_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s1_adv) begin
			s2_valid_q <= 1'b1;
		end else if (out_ready) begin
			s2_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			ready_s2   <= rs_ready;
			pop_s2     <= pop_now;
			read_s2    <= kind_s1 == vsd_pkg::KIND_READ;
			len_fwd_s2 <= len_fwd;
			len_val_s2 <= wr_len_q;
			mode_s2    <= mode_code;
			idx_s2     <= idx_s1;
		end
	end

	// length of a packet closed by this very beat bypasses the length RAM
	always_comb begin
		len_sel = len_fwd_s2 ? len_val_s2 : len_rdata;
		len_ext = ready_s2 ? LW'(len_sel) : '0;
	end

	assign out_valid     = s2_valid_q;
	assign packet_ready  = ready_s2;
	assign packet_length = len_ext[8:0];
	assign data_byte     = (read_s2 && ready_s2 && (LW'(idx_s2) < len_ext)) ? byte_rdata : 8'd0;
	assign pop_done      = pop_s2;
	assign receive_mode  = mode_s2;

	`VSD_ASSERT_NOW(a_collect_slot_free, mode_q == vsd_pkg::RX_COLLECT, !slot_ready_q[ws_q], "collecting into a ready slot")
	`VSD_ASSERT_NOW(a_len_in_range, 1'b1, wr_len_q <= LEN_W'(MTU), "write length beyond MTU")
	`VSD_ASSERT_NEXT(a_pop_moves_rs, s1_adv && pop_now, rs_q != $past(rs_q), "pop did not advance read slot")
	`VSD_ASSERT_NOW(a_ready_when_empty, !s2_valid_q, in_ready, "input stalled with empty output register")
	`VSD_ASSERT_NOW(a_pop_needs_ready, s2_valid_q && pop_s2, ready_s2, "pop reported on a slot not ready")

endmodule

>>> dv/testbench.sv
// Self-checking testbench for voting_symbol_deframer: scoreboard with a status predictor.
`timescale 1ns / 1ps

module testbench;

	localparam int RING    = vsd_pkg::SLOTS_DEF;
	localparam int PKT_MAX = vsd_pkg::MTU_DEF;
	localparam int LIMIT   = 400000;
	localparam int SHOWN   = 10;

	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic       ready;
		logic [8:0] length;
		logic [7:0] data;
		logic       popped;
		logic [1:0] mode;
	} status_t;

	class deframer_scoreboard;
		logic [1:0] rx_mode;
		logic [7:0] tally [256];
		logic       byte_voted;
		logic [7:0] best_count;
		logic [7:0] best_value;
		logic [7:0] slot_bytes [RING * PKT_MAX];
		logic [8:0] slot_len [RING];
		logic       slot_full [RING];
		logic [5:0] write_slot;
		logic [5:0] read_slot;
		status_t    status_due [$];
		int checked, errors, completed, pops, ring_full_hits, overflows, saturated;

		function new();
			rx_mode = vsd_pkg::MODE_WAIT;
			byte_voted = 1'b0;
			clear_tally();
			foreach (slot_len[i]) begin
				slot_len[i] = '0;
				slot_full[i] = 1'b0;
			end
			write_slot = '0;
			read_slot = '0;
		endfunction

		function void clear_tally();
			foreach (tally[i])
				tally[i] = '0;
			best_count = '0;
			best_value = '0;
		endfunction

		function void take_symbol(logic [9:0] v);
			logic [5:0] ws;
			logic [7:0] c;
			logic [8:0] n;
			ws = write_slot;
			if (v < vsd_pkg::CODE_DATA_END) begin
				if (rx_mode == vsd_pkg::MODE_COLLECT) begin
					c = tally[v[7:0]];
					if (c != 8'hFF)
						c = c + 8'd1;
					else
						saturated++;
					tally[v[7:0]] = c;
					byte_voted = 1'b1;
					// best value tracked as votes arrive: highest count, lowest value on ties
					if (c > best_count || (c == best_count && v[7:0] < best_value)) begin
						best_count = c;
						best_value = v[7:0];
					end
				end
			end else if (v >= vsd_pkg::CODE_PRE && v < vsd_pkg::CODE_SEP) begin
				if (rx_mode == vsd_pkg::MODE_WAIT) begin
					if (slot_full[ws]) begin
						rx_mode = vsd_pkg::MODE_DISCARD;
						ring_full_hits++;
					end else begin
						rx_mode = vsd_pkg::MODE_COLLECT;
						slot_len[ws] = '0;
					end
				end
			end else if (v >= vsd_pkg::CODE_SEP && v < vsd_pkg::CODE_POST) begin
				if (rx_mode == vsd_pkg::MODE_COLLECT && byte_voted) begin
					n = slot_len[ws];
					byte_voted = 1'b0;
					if (n >= PKT_MAX) begin
						rx_mode = vsd_pkg::MODE_DISCARD;
						overflows++;
					end else begin
						slot_bytes[ws * PKT_MAX + n] = best_value;
						slot_len[ws] = n + 9'd1;
					end
					clear_tally();
				end
			end else if (v >= vsd_pkg::CODE_POST && v <= vsd_pkg::CODE_LAST) begin
				if (rx_mode != vsd_pkg::MODE_COLLECT) begin
					if (!slot_full[ws])
						slot_len[ws] = '0;
				end else begin
					if (slot_len[ws] != '0) begin
						slot_full[ws] = 1'b1;
						write_slot = ws + 6'd1;
						completed++;
					end
					clear_tally();
					byte_voted = 1'b0;
				end
				rx_mode = vsd_pkg::MODE_WAIT;
			end
		endfunction

		// accepted input beat: advance the predictor and queue the status it reports
		function void note_beat(logic [1:0] k, logic [9:0] sym, logic [7:0] idx);
			status_t s;
			logic [5:0] rs;
			s = '0;
			if (k == vsd_pkg::KIND_SYMBOL)
				take_symbol(sym);
			rs = read_slot;
			s.ready = slot_full[rs];
			if (s.ready)
				s.length = slot_len[rs];
			if (k == vsd_pkg::KIND_READ && s.ready && idx < s.length)
				s.data = slot_bytes[rs * PKT_MAX + idx];
			if (k == vsd_pkg::KIND_POP && s.ready) begin
				slot_len[rs] = '0;
				slot_full[rs] = 1'b0;
				read_slot = rs + 6'd1;
				s.popped = 1'b1;
				pops++;
			end
			s.mode = rx_mode;
			status_due.push_back(s);
		endfunction

		function void flag(string what, int unsigned want, int unsigned got);
			errors++;
			if (errors <= SHOWN)
				$display("mismatch at result %0d, %s: expected %0d, got %0d",
					checked, what, want, got);
		endfunction

		function void check_status(status_t got);
			status_t want;
			if (status_due.size() == 0) begin
				flag("result with none pending", 0, 32'(got));
				return;
			end
			want = status_due.pop_front();
			checked++;
			if (got.ready !== want.ready)
				flag("packet_ready", 32'(want.ready), 32'(got.ready));
			if (got.length !== want.length)
				flag("packet_length", 32'(want.length), 32'(got.length));
			if (got.data !== want.data)
				flag("data_byte", 32'(want.data), 32'(got.data));
			if (got.popped !== want.popped)
				flag("pop_done", 32'(want.popped), 32'(got.popped));
			if (got.mode !== want.mode)
				flag("receive_mode", 32'(want.mode), 32'(got.mode));
		endfunction

		function int pending();
			return status_due.size();
		endfunction

		function logic [8:0] oldest_length();
			return slot_full[read_slot] ? slot_len[read_slot] : 9'd0;
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] kind = '0;
	logic [9:0] symbol_value = '0;
	logic [7:0] byte_index = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       packet_ready;
	logic [8:0] packet_length;
	logic [7:0] data_byte;
	logic       pop_done;
	logic [1:0] receive_mode;

	deframer_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int beats = 0;

	voting_symbol_deframer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.symbol_value (symbol_value),
		.byte_index   (byte_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.packet_ready (packet_ready),
		.packet_length(packet_length),
		.data_byte    (data_byte),
		.pop_done     (pop_done),
		.receive_mode (receive_mode)
	);

	always #5 clk = ~clk;

	// result side: check accepted beats, stall at random
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_status({packet_ready, packet_length, data_byte, pop_done, receive_mode});
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	initial begin : watchdog
		int cyc;
		cyc = 0;
		while (cyc < LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("timeout after %0d cycles, %0d results pending", cyc, sb.pending());
		$display("testbench: errors");
		$finish;
	end

	task automatic send_beat(input logic [1:0] k, input logic [9:0] sym, input logic [7:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		symbol_value <= sym;
		byte_index <= idx;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_beat(k, sym, idx);
		beats++;
	endtask

	task automatic send_symbol(input logic [9:0] code);
		send_beat(vsd_pkg::KIND_SYMBOL, code, 8'($urandom_range(255)));
	endtask

	// always waits on the clock first, so in_valid is never dropped and raised in one step
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [9:0] pick_pre();
		return vsd_pkg::CODE_PRE + 10'($urandom_range(4));
	endfunction

	function automatic logic [9:0] pick_sep();
		return vsd_pkg::CODE_SEP + 10'($urandom_range(4));
	endfunction

	function automatic logic [9:0] pick_post();
		return vsd_pkg::CODE_POST + 10'($urandom_range(5));
	endfunction

	function automatic logic [9:0] pick_ignored();
		if ($urandom_range(1) == 0)
			return vsd_pkg::CODE_DATA_END + 10'($urandom_range(13));
		return vsd_pkg::CODE_LAST + 10'd1 + 10'($urandom_range(1023 - 286));
	endfunction

	function automatic logic [7:0] pick_byte();
		if ($urandom_range(7) == 0)
			return $urandom_range(1) ? 8'hFF : 8'h00;
		return 8'($urandom_range(255));
	endfunction

	task automatic read_oldest();
		logic [8:0] len;
		logic [7:0] idx;
		len = sb.oldest_length();
		if (len != 0 && $urandom_range(3) != 0)
			idx = 8'($urandom_range(len - 1));
		else
			idx = 8'($urandom_range(255));
		send_beat(vsd_pkg::KIND_READ, 10'($urandom_range(1023)), idx);
	endtask

	// votes mostly for one value, with stray votes and ignored codes mixed in
	task automatic send_byte(input int votes);
		logic [7:0] v;
		v = pick_byte();
		repeat (votes) begin
			if ($urandom_range(11) == 0)
				send_symbol(pick_ignored());
			send_symbol(10'(($urandom_range(3) == 0) ? pick_byte() : v));
		end
		send_symbol(pick_sep());
	endtask

	task automatic send_packet(input int nbytes, input int max_votes);
		send_symbol(pick_pre());
		repeat (nbytes)
			send_byte($urandom_range(1, max_votes));
		send_symbol(pick_post());
	endtask

	task automatic broken_sequence();
		case ($urandom_range(3))
			0: begin
				// votes never committed, so the packet closes empty
				send_symbol(pick_pre());
				repeat ($urandom_range(1, 3))
					send_symbol(10'(pick_byte()));
				send_symbol(pick_post());
			end
			1: begin
				send_symbol(pick_pre());
				send_byte($urandom_range(1, 3));
				send_symbol(pick_sep());
				send_symbol(pick_post());
			end
			2: begin
				send_symbol(pick_pre());
				send_byte($urandom_range(1, 3));
				send_symbol(pick_pre());
				send_symbol(pick_post());
			end
			default: begin
				send_symbol(10'(pick_byte()));
				send_symbol(pick_sep());
				send_symbol(pick_post());
			end
		endcase
	endtask

	// more complete packets than slots: the last preambles land on a full ring
	task automatic fill_ring();
		repeat (RING + 2) begin
			send_symbol(pick_pre());
			send_symbol(10'(pick_byte()));
			send_symbol(pick_sep());
			send_symbol(pick_post());
			if ($urandom_range(9) == 0)
				read_oldest();
		end
	endtask

	// first byte saturates its vote counter; one byte past the MTU forces a discard
	task automatic long_packet();
		logic [7:0] v;
		v = 8'($urandom_range(1, 254));
		send_symbol(pick_pre());
		repeat (PKT_MAX + 4)
			send_symbol(10'(v));
		send_symbol(pick_sep());
		repeat (PKT_MAX) begin
			send_symbol(10'(pick_byte()));
			send_symbol(pick_sep());
			if ($urandom_range(31) == 0)
				read_oldest();
		end
		send_symbol(pick_post());
	endtask

	task automatic run_mix(input int quota, input int pop_pct);
		int start;
		int r;
		start = beats;
		while (beats - start < quota) begin
			r = $urandom_range(99);
			if (r < pop_pct)
				send_beat(vsd_pkg::KIND_POP, 10'($urandom_range(1023)),
					8'($urandom_range(255)));
			else if (r < pop_pct + 12)
				read_oldest();
			else if (r < pop_pct + 20)
				send_beat(2'($urandom_range(3)), 10'($urandom_range(1023)),
					8'($urandom_range(255)));
			else if (r < pop_pct + 28)
				broken_sequence();
			else if (r < pop_pct + 30)
				hold_until_drained();
			else if ($urandom_range(9) == 0)
				send_packet($urandom_range(8, 30), 4);
			else
				send_packet($urandom_range(1, 4), 4);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 13;
		recv_idle_pct = 76;
		send_beat(vsd_pkg::KIND_POP, '0, '0);
		send_beat(vsd_pkg::KIND_READ, 10'h3FF, 8'hFF);
		send_beat(KIND_UNUSED, 10'h2AA, 8'h55);
		send_symbol(10'd0);
		send_symbol(vsd_pkg::CODE_SEP);
		send_symbol(vsd_pkg::CODE_POST);
		send_symbol(vsd_pkg::CODE_DATA_END);
		send_symbol(vsd_pkg::CODE_PRE - 10'd1);
		send_symbol(vsd_pkg::CODE_LAST + 10'd1);
		send_symbol(10'h3FF);
		send_symbol(vsd_pkg::CODE_PRE);
		send_symbol(vsd_pkg::CODE_PRE + 10'd4);
		send_symbol(vsd_pkg::CODE_SEP);
		send_symbol(vsd_pkg::CODE_LAST);
		send_symbol(vsd_pkg::CODE_PRE + 10'd2);
		send_symbol(10'd7);
		send_symbol(10'd3);
		send_symbol(vsd_pkg::CODE_SEP + 10'd4);
		send_symbol(10'd255);
		send_symbol(vsd_pkg::CODE_SEP + 10'd2);
		send_symbol(vsd_pkg::CODE_POST + 10'd3);
		send_beat(vsd_pkg::KIND_READ, '0, 8'd0);
		send_beat(vsd_pkg::KIND_READ, '0, 8'd1);
		send_beat(vsd_pkg::KIND_READ, '0, 8'd2);
		send_beat(vsd_pkg::KIND_POP, '0, '0);
		send_beat(vsd_pkg::KIND_POP, '0, '0);

		fill_ring();
		run_mix(40, 3);

		send_idle_pct = 76;
		recv_idle_pct = 13;
		hold_until_drained();
		run_mix(130, 30);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_until_drained();
		// one pop frees the write slot even when the ring is full
		send_beat(vsd_pkg::KIND_POP, '0, '0);
		long_packet();
		run_mix(70, 12);

		hold_until_drained();
		repeat (8) @(posedge clk);
		$display("summary: %0d beats, %0d results checked, %0d packets completed, %0d pops",
			beats, sb.checked, sb.completed, sb.pops);
		$display("summary: %0d full-ring discards, %0d overflow discards, %0d saturated votes",
			sb.ring_full_hits, sb.overflows, sb.saturated);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end
endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/vsd_pkg.sv
rtl/core/vsd_ram.sv
rtl/core/vsd_vote.sv
rtl/core/voting_symbol_deframer.sv
dv/testbench.sv
